>>> rtl/core/skyf_pkg.sv
// Shared types and constants of the scalar Kalman yaw fusion block.
package skyf_pkg;

   // Sequencer states of the filter core.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEN,
      ST_NUM,
      ST_DIV,
      ST_PRE,
      ST_INN,
      ST_MUL,
      ST_FIN
   } state_type;

   // Register indexes on the configuration channel.
   localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
   localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
   localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

   // Reset values of the configuration registers and of the variance.
   localparam logic [31:0] PROCESS_NOISE_RESET = 32'd107374;
   localparam logic [31:0] MEASURE_NOISE_RESET = 32'd10737418;
   localparam logic [23:0] SAMPLE_PERIOD_RESET = 24'd83886;
   localparam logic [31:0] VARIANCE_RESET      = 32'h4000_0000;

   // One in Q1.30, as a gain value.
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // Bit-serial step counts: the sample period has 24 bits, the gain 31.
   localparam logic [4:0] DT_BITS   = 5'd24;
   localparam logic [4:0] STEP_LAST = 5'd30;

endpackage

>>> rtl/core/scalar_kalman_yaw_fusion.sv
// Top level of the scalar Kalman yaw fusion block with its bit-serial datapath.
//
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata[31:0] yaw_rate, [63:32] measured_yaw
// rsp      out        rsp_tvalid/tready    tdata[31:0] yaw_estimate, [62:32] gain
// csr      in         csr_valid/ready      csr_index, csr_data
//
// An item passes through the restoring gain divider (the 24-bit prediction
// multiply runs beside it), then the two shift-and-add multipliers for the
// correction and the new variance, with set-up and write-back states around
// them; no new input is accepted until the core is back in idle.
// Reset is synchronous and active high; it loads the register defaults, a
// zero estimate and a variance of one. A result waits in the output register
// while the next item is accepted; write-back stalls only if that register is
// still full when the following result is ready.
module scalar_kalman_yaw_fusion (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] yaw_rate, [63:32] measured_yaw
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] yaw_estimate, [62:32] gain, [63] zero
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Control and state registers
   skyf_pkg::state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [23:0] period_ff, period_in;
   logic [31:0] est_ff, est_in;
   logic [31:0] var_ff, var_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [31:0] rate_ff, rate_in;
   logic [31:0] meas_ff, meas_in;
   logic [31:0] pp_ff, pp_in;
   logic [32:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [30:0] nlo_ff, nlo_in;
   logic [30:0] quo_ff, quo_in;
   logic [23:0] dtsr_ff, dtsr_in;
   logic [31:0] dhi_ff, dhi_in;
   logic        dround_ff, dround_in;
   logic [31:0] pre_ff, pre_in;
   logic [30:0] k_ff, k_in;
   logic [32:0] innov_ff, innov_in;
   logic [30:0] ksr_ff, ksr_in;
   logic [30:0] msr_ff, msr_in;
   logic [32:0] chi_ff, chi_in;
   logic [1:0]  cbits_ff, cbits_in;
   logic [31:0] phi_ff, phi_in;
   logic [1:0]  pbits_ff, pbits_in;
   logic [30:0] rsp_gain_ff, rsp_gain_in;

   // Combinational intermediates
   logic [32:0] pp_sum;
   logic [62:0] num;
   logic [33:0] rsh;
   logic [33:0] rdiff;
   logic        qbit;
   logic [32:0] dsum;
   logic [32:0] delta;
   logic [33:0] pre_sum;
   logic [33:0] csum;
   logic [32:0] psum;
   logic [33:0] corr;
   logic [34:0] est_sum;
   logic [32:0] np;
   logic        slot_free;

   // Saturate a 34-bit signed sum to the signed 32-bit range.
   function automatic logic [31:0] sat34(input logic [33:0] v);
      logic [31:0] res;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         res = v[31:0];
      end else if (v[33]) begin
         res = 32'h8000_0000;
      end else begin
         res = 32'h7FFF_FFFF;
      end
      return res;
   endfunction

   // Saturate a 35-bit signed sum to the signed 32-bit range.
   function automatic logic [31:0] sat35(input logic [34:0] v);
      logic [31:0] res;
      if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
         res = v[31:0];
      end else if (v[34]) begin
         res = 32'h8000_0000;
      end else begin
         res = 32'h7FFF_FFFF;
      end
      return res;
   endfunction

   // Datapath arithmetic, one narrow step of each serial unit per cycle.
   always_comb begin
      pp_sum  = {1'b0, var_ff} + {1'b0, q_ff};
      num     = {1'b0, pp_ff, 30'd0} + {31'd0, den_ff[32:1]};
      rsh     = {rem_ff, nlo_ff[30]};
      rdiff   = rsh - {1'b0, den_ff};
      qbit    = (rsh >= {1'b0, den_ff});
      dsum    = {dhi_ff[31], dhi_ff} + (dtsr_ff[0] ? {rate_ff[31], rate_ff} : 33'd0);
      delta   = {dhi_ff[31], dhi_ff} + {32'd0, dround_ff};
      pre_sum = {{2{est_ff[31]}}, est_ff} + {delta[32], delta};
      csum    = {chi_ff[32], chi_ff} + (ksr_ff[0] ? {innov_ff[32], innov_ff} : 34'd0);
      psum    = {1'b0, phi_ff} + (msr_ff[0] ? {1'b0, pp_ff} : 33'd0);
      corr    = {chi_ff, cbits_ff[1]} + {33'd0, cbits_ff[0]};
      est_sum = {{3{pre_ff[31]}}, pre_ff} + {corr[33], corr};
      np      = {phi_ff, pbits_ff[1]} + {32'd0, pbits_ff[0]};
   end

   // Next state and register values of the sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      period_in    = period_ff;
      est_in       = est_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff;
      rate_in      = rate_ff;
      meas_in      = meas_ff;
      pp_in        = pp_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      nlo_in       = nlo_ff;
      quo_in       = quo_ff;
      dtsr_in      = dtsr_ff;
      dhi_in       = dhi_ff;
      dround_in    = dround_ff;
      pre_in       = pre_ff;
      k_in         = k_ff;
      innov_in     = innov_ff;
      ksr_in       = ksr_ff;
      msr_in       = msr_ff;
      chi_in       = chi_ff;
      cbits_in     = cbits_ff;
      phi_in       = phi_ff;
      pbits_in     = pbits_ff;
      rsp_gain_in  = rsp_gain_ff;

      // Configuration writes; an index beyond the list is ignored.
      if (csr_valid) begin
         case (csr_index)
            skyf_pkg::REG_PROCESS_NOISE: q_in      = csr_data;
            skyf_pkg::REG_MEASURE_NOISE: r_in      = csr_data;
            skyf_pkg::REG_SAMPLE_PERIOD: period_in = csr_data[23:0];
            default: ;
         endcase
      end

      // The output register empties on a result transfer.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      slot_free = !rsp_valid_ff || rsp_tready;

      case (state_ff)
         skyf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               rate_in  = req_tdata[31:0];
               meas_in  = req_tdata[63:32];
               pp_in    = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
               dtsr_in  = period_ff;
               dhi_in   = 32'd0;
               state_in = skyf_pkg::ST_DEN;
            end
         end
         skyf_pkg::ST_DEN: begin
            den_in   = {1'b0, pp_ff} + {1'b0, r_ff};
            state_in = skyf_pkg::ST_NUM;
         end
         skyf_pkg::ST_NUM: begin
            // Rounded numerator: prior variance times one, plus half the divisor.
            rem_in   = {1'b0, num[62:31]};
            nlo_in   = num[30:0];
            cnt_in   = 5'd0;
            state_in = skyf_pkg::ST_DIV;
         end
         skyf_pkg::ST_DIV: begin
            // One quotient bit of the gain per cycle.
            rem_in = qbit ? rdiff[32:0] : rsh[32:0];
            nlo_in = {nlo_ff[29:0], 1'b0};
            quo_in = {quo_ff[29:0], qbit};
            // One bit of the sample period per cycle for the prediction.
            if (cnt_ff < skyf_pkg::DT_BITS) begin
               dhi_in    = dsum[32:1];
               dround_in = dsum[0];
               dtsr_in   = {1'b0, dtsr_ff[23:1]};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == skyf_pkg::STEP_LAST) begin
               state_in = skyf_pkg::ST_PRE;
            end
         end
         skyf_pkg::ST_PRE: begin
            pre_in   = sat34(pre_sum);
            k_in     = (den_ff == 33'd0) ? 31'd0 : quo_ff;
            state_in = skyf_pkg::ST_INN;
         end
         skyf_pkg::ST_INN: begin
            innov_in = {meas_ff[31], meas_ff} - {pre_ff[31], pre_ff};
            ksr_in   = k_ff;
            msr_in   = skyf_pkg::Q30_ONE - k_ff;
            chi_in   = 33'd0;
            phi_in   = 32'd0;
            cnt_in   = 5'd0;
            state_in = skyf_pkg::ST_MUL;
         end
         skyf_pkg::ST_MUL: begin
            // Correction and new variance, one multiplier bit per cycle each.
            chi_in   = csum[33:1];
            cbits_in = {csum[0], cbits_ff[1]};
            ksr_in   = {1'b0, ksr_ff[30:1]};
            phi_in   = psum[32:1];
            pbits_in = {psum[0], pbits_ff[1]};
            msr_in   = {1'b0, msr_ff[30:1]};
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == skyf_pkg::STEP_LAST) begin
               state_in = skyf_pkg::ST_FIN;
            end
         end
         skyf_pkg::ST_FIN: begin
            // Write back once the output register can take the result.
            if (slot_free) begin
               est_in       = sat35(est_sum);
               var_in       = np[31:0];
               rsp_gain_in  = k_ff;
               rsp_valid_in = 1'b1;
               state_in     = skyf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skyf_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and state registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skyf_pkg::ST_IDLE;
         cnt_ff       <= 5'd0;
         q_ff         <= skyf_pkg::PROCESS_NOISE_RESET;
         r_ff         <= skyf_pkg::MEASURE_NOISE_RESET;
         period_ff    <= skyf_pkg::SAMPLE_PERIOD_RESET;
         est_ff       <= 32'd0;
         var_ff       <= skyf_pkg::VARIANCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         period_ff    <= period_in;
         est_ff       <= est_in;
         var_ff       <= var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rate_ff     <= rate_in;
      meas_ff     <= meas_in;
      pp_ff       <= pp_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      nlo_ff      <= nlo_in;
      quo_ff      <= quo_in;
      dtsr_ff     <= dtsr_in;
      dhi_ff      <= dhi_in;
      dround_ff   <= dround_in;
      pre_ff      <= pre_in;
      k_ff        <= k_in;
      innov_ff    <= innov_in;
      ksr_ff      <= ksr_in;
      msr_ff      <= msr_in;
      chi_ff      <= chi_in;
      cbits_ff    <= cbits_in;
      phi_ff      <= phi_in;
      pbits_ff    <= pbits_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   // Port drive. The estimate register changes only when a new result is loaded.
   assign req_tready = (state_ff == skyf_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_gain_ff, est_ff};

   // The reported gain never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[62:32] <= skyf_pkg::Q30_ONE))
      else $error("gain above one");

   // An accepted item keeps the core busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while busy");

   // A zero divisor yields a zero gain.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skyf_pkg::ST_PRE && den_ff == 33'd0) |=> (k_ff == 31'd0))
      else $error("nonzero gain from zero divisor");

   // Write-back with a free output register presents a result and frees the input.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skyf_pkg::ST_FIN && slot_free) |=> (rsp_tvalid && req_tready))
      else $error("result not presented after write-back");

endmodule
